FILE: rtl/pce_pkg.sv
package pce_pkg;

  // Table sizes and word widths.
  localparam int MAX_SEGMENTS = 16;
  localparam int VALUE_WIDTH  = 32;
  localparam int RES_W        = 48;
  localparam int COEF_PER_SEG = 12;
  localparam int BP_DEPTH     = MAX_SEGMENTS + 1;
  localparam int COEF_DEPTH   = MAX_SEGMENTS * COEF_PER_SEG;
  localparam int BP_AW        = $clog2(BP_DEPTH);
  localparam int COEF_AW      = $clog2(COEF_DEPTH);
  localparam int SEG_W        = 4;
  localparam int CNT_W        = 5;
  localparam int TOL_W        = 16;
  localparam int CMP_W        = VALUE_WIDTH + 2;
  localparam int MUL_CHUNK    = 16;
  localparam int MUL_STEPS    = RES_W / MUL_CHUNK;

  // Input operation codes.
  localparam logic [1:0] OP_LOAD_BP   = 2'd0;
  localparam logic [1:0] OP_LOAD_COEF = 2'd1;
  localparam logic [1:0] OP_EVAL      = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_SEGMENT_COUNT = 1'b0;
  localparam logic CFG_TOLERANCE     = 1'b1;

  localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE, ST_LO, ST_HI, ST_SRCH, ST_START, ST_S2, ST_S2W, ST_S3, ST_S3W,
    ST_RDB, ST_BASE, ST_RDT, ST_MST, ST_MWT, ST_NEXT, ST_EMIT
  } pce_state_t;

  // Request to the shared multiplier.
  typedef struct packed {
    logic                    start;
    logic signed [RES_W-1:0] a;
    logic signed [RES_W-1:0] b;
  } pce_mul_req_t;

  // Clamp a wider signed value to the result range.
  function automatic logic signed [RES_W-1:0] sat48(input logic signed [RES_W+3:0] v);
    logic signed [RES_W+3:0] hi;
    logic signed [RES_W+3:0] lo;
    hi = {{4{RES_MAX[RES_W-1]}}, RES_MAX};
    lo = {{4{RES_MIN[RES_W-1]}}, RES_MIN};
    if (v > hi) begin
      return RES_MAX;
    end else if (v < lo) begin
      return RES_MIN;
    end
    return v[RES_W-1:0];
  endfunction

  // Word address of one coefficient in the coefficient memory.
  function automatic logic [COEF_AW-1:0] coef_addr(input logic [SEG_W-1:0] seg,
                                                   input logic [1:0] ax,
                                                   input logic [1:0] pw);
    logic [COEF_AW-1:0] base;
    base = COEF_AW'(seg) * COEF_AW'(COEF_PER_SEG);
    return base + COEF_AW'({ax, 2'b00}) + COEF_AW'(pw);
  endfunction

endpackage

FILE: rtl/pce_mul.sv
module pce_mul import pce_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  pce_mul_req_t            req,
  output logic                    done,
  output logic signed [RES_W-1:0] p
);

  logic [RES_W-1:0]     ua;
  logic [RES_W-1:0]     ub;
  logic [2*RES_W-1:0]   acc;
  logic                 neg;
  logic [1:0]           cnt;
  logic [RES_W-1:0]     ua_in;
  logic [RES_W-1:0]     ub_in;
  logic [RES_W+MUL_CHUNK-1:0] part;
  logic [2*RES_W-MUL_CHUNK-1:0] mag;
  logic                 big;

  // Operand magnitudes; the most negative value maps to its exact magnitude.
  assign ua_in = req.a[RES_W-1] ? (~req.a + 1'b1) : req.a;
  assign ub_in = req.b[RES_W-1] ? (~req.b + 1'b1) : req.b;

  // One sixteen-bit digit of the second operand per cycle, top digit first.
  assign part = ua * ub[RES_W-1:RES_W-MUL_CHUNK];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= 2'd0;
      done <= 1'b0;
    end else if (req.start) begin
      cnt  <= 2'(MUL_STEPS);
      done <= 1'b0;
    end else if (cnt != 2'd0) begin
      cnt  <= cnt - 2'd1;
      done <= (cnt == 2'd1);
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      ua  <= ua_in;
      ub  <= ub_in;
      neg <= req.a[RES_W-1] ^ req.b[RES_W-1];
      acc <= '0;
    end else if (cnt != 2'd0) begin
      acc <= {acc[2*RES_W-MUL_CHUNK-1:0], {MUL_CHUNK{1'b0}}}
             + (2*RES_W)'(part);
      ub  <= {ub[RES_W-MUL_CHUNK-1:0], {MUL_CHUNK{1'b0}}};
    end
  end

  // Drop the fraction, truncating towards zero, and clamp to the result range.
  assign mag = acc[2*RES_W-1:MUL_CHUNK];
  assign big = (mag[2*RES_W-MUL_CHUNK-1:RES_W-1] != '0);

  always_comb begin
    if (neg) begin
      p = big ? RES_MIN : (~mag[RES_W-1:0] + 1'b1);
    end else begin
      p = big ? RES_MAX : mag[RES_W-1:0];
    end
  end

  a_start_load: assert property (@(posedge clk) disable iff (rst)
    req.start |=> (cnt == 2'(MUL_STEPS)))
    else $error("multiplier did not load its step count");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (cnt == 2'd0))
    else $error("multiplier flagged done while still stepping");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (cnt != 2'd0 && !req.start) |=> (cnt == $past(cnt) - 2'd1))
    else $error("multiplier step count skipped");

endmodule

FILE: rtl/piecewise_cubic_evaluator.sv
// Channel   Direction  Handshake              Word
// input     in         in_valid / in_ready    op, entry_index, axis, power, load_value,
//                                             param, max_order
// output    out        out_valid / out_ready  order, x_value, y_value, z_value, segment,
//                                             in_range, last
// config    in         cfg_write_en           cfg_index, cfg_data
//
// An evaluation out of the domain emits a single word.
// An evaluation in the domain searches i segments (1 to 16, one breakpoint memory
// read each), and then builds the vector of each order k in turn: each product
// waits on the shared multiplier.
// Reset is synchronous and clears control state only; the tables hold no reset value.
// A stalled output keeps its word; the next input word is taken while it waits.
module piecewise_cubic_evaluator import pce_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    op,
  input  logic [4:0]                    entry_index,
  input  logic [1:0]                    axis,
  input  logic [1:0]                    power,
  input  logic signed [VALUE_WIDTH-1:0] load_value,
  input  logic signed [VALUE_WIDTH-1:0] param,
  input  logic [1:0]                    max_order,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    order,
  output logic signed [RES_W-1:0]       x_value,
  output logic signed [RES_W-1:0]       y_value,
  output logic signed [RES_W-1:0]       z_value,
  output logic [SEG_W-1:0]              segment,
  output logic                          in_range,
  output logic                          last,
  input  logic                          cfg_write_en,
  input  logic                          cfg_index,
  input  logic [TOL_W-1:0]              cfg_data
);

  pce_state_t state, state_next;

  logic [VALUE_WIDTH-1:0] bp_mem   [0:BP_DEPTH-1];
  logic [VALUE_WIDTH-1:0] coef_mem [0:COEF_DEPTH-1];
  logic [VALUE_WIDTH-1:0] bp_rdata;
  logic [VALUE_WIDTH-1:0] coef_rdata;
  logic [BP_AW-1:0]       bp_raddr;
  logic [COEF_AW-1:0]     coef_raddr;

  logic [CNT_W-1:0]        seg_cnt;
  logic [TOL_W-1:0]        tol;
  logic [CNT_W-1:0]        n_act;
  logic signed [VALUE_WIDTH-1:0] t;
  logic signed [VALUE_WIDTH-1:0] t0;
  logic [1:0]              maxo;
  logic [SEG_W-1:0]        idx;
  logic [SEG_W-1:0]        seg;
  logic signed [RES_W-1:0] s;
  logic signed [RES_W-1:0] s2;
  logic signed [RES_W-1:0] s3;
  logic signed [RES_W-1:0] s3x2;
  logic [1:0]              k;
  logic [1:0]              ax;
  logic [1:0]              j;
  logic signed [RES_W-1:0] r;
  logic signed [RES_W-1:0] vx;
  logic signed [RES_W-1:0] vy;
  logic signed [RES_W-1:0] vz;
  logic                    oor;

  logic                    in_acc;
  logic                    out_load;
  logic                    oor_now;
  logic                    hit;
  logic                    stop;
  logic signed [CMP_W-1:0] t34;
  logic signed [CMP_W-1:0] t0_34;
  logic signed [CMP_W-1:0] rd34;
  logic signed [CMP_W-1:0] tol34;
  logic signed [CMP_W-1:0] lo_lim;
  logic signed [CMP_W-1:0] hi_lim;
  logic signed [CMP_W-1:0] d;
  logic signed [RES_W-1:0] c48;
  logic signed [RES_W-1:0] c_scaled;
  logic signed [RES_W-1:0] basis;
  logic signed [RES_W-1:0] s2x;
  logic signed [RES_W-1:0] s6x;
  logic signed [RES_W+3:0] s2_wide;

  pce_mul_req_t            mul_req;
  logic                    mul_done;
  logic signed [RES_W-1:0] mul_p;

  pce_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_req),
    .done (mul_done),
    .p    (mul_p)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_cnt <= CNT_W'(1);
      tol     <= TOL_W'(1);
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_SEGMENT_COUNT: seg_cnt <= cfg_data[CNT_W-1:0];
        CFG_TOLERANCE:     tol     <= cfg_data;
        default:           ;
      endcase
    end
  end

  // Segments in use, clamped to the table.
  always_comb begin
    if (seg_cnt == '0) begin
      n_act = CNT_W'(1);
    end else if (seg_cnt > CNT_W'(MAX_SEGMENTS)) begin
      n_act = CNT_W'(MAX_SEGMENTS);
    end else begin
      n_act = seg_cnt;
    end
  end

  assign in_acc = in_valid && in_ready;

  // Table writes from load words; reads are registered.
  always_ff @(posedge clk) begin
    if (in_acc && op == OP_LOAD_BP && entry_index <= 5'(MAX_SEGMENTS)) begin
      bp_mem[entry_index[BP_AW-1:0]] <= load_value;
    end
    bp_rdata <= bp_mem[bp_raddr];
  end

  always_ff @(posedge clk) begin
    if (in_acc && op == OP_LOAD_COEF && entry_index < 5'(MAX_SEGMENTS) && axis != 2'd3) begin
      coef_mem[coef_addr(entry_index[SEG_W-1:0], axis, power)] <= load_value;
    end
    coef_rdata <= coef_mem[coef_raddr];
  end

  // Domain and breakpoint compares at a width that cannot overflow.
  assign t34    = CMP_W'(t);
  assign t0_34  = CMP_W'(t0);
  assign rd34   = CMP_W'($signed(bp_rdata));
  assign tol34  = CMP_W'(tol);
  assign lo_lim = t0_34 - tol34;
  assign hi_lim = rd34 + tol34;
  assign oor_now = (t34 < lo_lim) || (t34 > hi_lim);
  assign d      = t34 - rd34;
  assign hit    = (d <= tol34 && d >= -tol34) || (t34 < rd34);
  assign stop   = hit || (CNT_W'(idx) == n_act - CNT_W'(1));

  // Coefficient scaling and derivative bases; none of these can overflow.
  assign c48     = RES_W'($signed(coef_rdata));
  assign s2x     = s <<< 1;
  assign s6x     = (s <<< 2) + (s <<< 1);
  assign s2_wide = (RES_W+4)'(s2);

  always_comb begin
    case (k)
      2'd2:    c_scaled = c48 <<< 1;
      2'd3:    c_scaled = (c48 <<< 2) + (c48 <<< 1);
      default: c_scaled = c48;
    endcase
  end

  always_comb begin
    case ({k, j})
      {2'd0, 2'd1}: basis = s;
      {2'd0, 2'd2}: basis = s2;
      {2'd0, 2'd3}: basis = s3;
      {2'd1, 2'd2}: basis = s2x;
      {2'd1, 2'd3}: basis = s3x2;
      default:      basis = s6x;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_acc && op == OP_EVAL) state_next = ST_LO;
      ST_LO:    state_next = ST_HI;
      ST_HI:    state_next = oor_now ? ST_EMIT : ST_SRCH;
      ST_SRCH:  if (stop) state_next = ST_START;
      ST_START: state_next = ST_S2;
      ST_S2:    state_next = ST_S2W;
      ST_S2W:   if (mul_done) state_next = ST_S3;
      ST_S3:    state_next = ST_S3W;
      ST_S3W:   if (mul_done) state_next = ST_RDB;
      ST_RDB:   state_next = ST_BASE;
      ST_BASE:  state_next = (k == 2'd3) ? ST_NEXT : ST_RDT;
      ST_RDT:   state_next = ST_MST;
      ST_MST:   state_next = ST_MWT;
      ST_MWT:   if (mul_done) state_next = (j == 2'd3) ? ST_NEXT : ST_RDT;
      ST_NEXT:  state_next = (ax == 2'd2) ? ST_EMIT : ST_RDB;
      ST_EMIT:  if (out_load) state_next = (oor || k == maxo) ? ST_IDLE : ST_RDB;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control outputs: handshake, memory addresses and multiplier requests.
  always_comb begin
    in_ready      = 1'b0;
    bp_raddr      = '0;
    coef_raddr    = coef_addr(seg, ax, k);
    mul_req.start = 1'b0;
    mul_req.a     = s;
    mul_req.b     = s;
    out_load      = 1'b0;
    unique case (state)
      ST_IDLE:  in_ready = 1'b1;
      ST_LO:    bp_raddr = n_act[BP_AW-1:0];
      ST_HI:    bp_raddr = BP_AW'(1);
      ST_SRCH:  bp_raddr = stop ? BP_AW'(idx) : BP_AW'(idx) + BP_AW'(2);
      ST_S2:    mul_req.start = 1'b1;
      ST_S3: begin
        mul_req.start = 1'b1;
        mul_req.a     = s2;
      end
      ST_RDT:   coef_raddr = coef_addr(seg, ax, j);
      ST_MST: begin
        mul_req.start = 1'b1;
        mul_req.a     = c48;
        mul_req.b     = basis;
      end
      ST_EMIT:  out_load = !out_valid || out_ready;
      default:  ;
    endcase
  end

  // Evaluation datapath.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          t    <= param;
          maxo <= max_order;
        end
        oor <= 1'b0;
      end
      ST_LO: t0 <= $signed(bp_rdata);
      ST_HI: begin
        oor <= oor_now;
        idx <= '0;
      end
      ST_SRCH: begin
        if (stop) begin
          seg <= idx;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      ST_START: s <= RES_W'(t34 - rd34);
      ST_S2W: if (mul_done) s2 <= mul_p;
      ST_S3W: begin
        if (mul_done) begin
          s3   <= mul_p;
          s3x2 <= sat48((s2_wide <<< 1) + s2_wide);
          k    <= 2'd0;
          ax   <= 2'd0;
        end
      end
      ST_BASE: begin
        r <= c_scaled;
        j <= k + 2'd1;
      end
      ST_MWT: begin
        if (mul_done) begin
          r <= sat48((RES_W+4)'(r) + (RES_W+4)'(mul_p));
          j <= j + 2'd1;
        end
      end
      ST_NEXT: begin
        case (ax)
          2'd0:    vx <= r;
          2'd1:    vy <= r;
          default: vz <= r;
        endcase
        ax <= ax + 2'd1;
      end
      ST_EMIT: begin
        if (out_load) begin
          k  <= k + 2'd1;
          ax <= 2'd0;
        end
      end
      default: ;
    endcase
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (oor) begin
        order    <= 2'd0;
        x_value  <= '0;
        y_value  <= '0;
        z_value  <= '0;
        segment  <= '0;
        in_range <= 1'b0;
        last     <= 1'b1;
      end else begin
        order    <= k;
        x_value  <= vx;
        y_value  <= vy;
        z_value  <= vz;
        segment  <= seg;
        in_range <= 1'b1;
        last     <= (k == maxo);
      end
    end
  end

  a_search_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SRCH) |-> (CNT_W'(idx) < n_act))
    else $error("breakpoint search ran past the last segment");

  a_miss_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !in_range) |-> (order == 2'd0 && last))
    else $error("out-of-domain word is not a single order-zero word");

  a_mul_owner: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == ST_S2W || state == ST_S3W || state == ST_MWT))
    else $error("product finished while nothing waited on it");

endmodule

FILE: tb/pce_checker.sv
`timescale 1ns / 100ps

// Watches the input, output and register ports of the evaluator, keeps its own
// copy of the tables and registers, and checks every output word in order.
module pce_checker import pce_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [1:0]                    op,
  input  logic [4:0]                    entry_index,
  input  logic [1:0]                    axis,
  input  logic [1:0]                    power,
  input  logic signed [VALUE_WIDTH-1:0] load_value,
  input  logic signed [VALUE_WIDTH-1:0] param,
  input  logic [1:0]                    max_order,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [1:0]                    order,
  input  logic signed [RES_W-1:0]       x_value,
  input  logic signed [RES_W-1:0]       y_value,
  input  logic signed [RES_W-1:0]       z_value,
  input  logic [SEG_W-1:0]              segment,
  input  logic                          in_range,
  input  logic                          last,
  input  logic                          cfg_write_en,
  input  logic                          cfg_index,
  input  logic [TOL_W-1:0]              cfg_data,
  output int                            fail_count,
  output int                            pending,
  output int                            vectors_checked
);

  typedef struct {
    logic [1:0]              order;
    logic signed [RES_W-1:0] xv;
    logic signed [RES_W-1:0] yv;
    logic signed [RES_W-1:0] zv;
    logic [SEG_W-1:0]        seg;
    logic                    in_range;
    logic                    last;
  } curve_vector_t;

  localparam longint LIM47 = 64'sh0000_8000_0000_0000;

  longint        bp_copy [0:MAX_SEGMENTS];
  longint        coef_copy [0:COEF_DEPTH-1];
  logic [4:0]    seg_count_reg;
  logic [15:0]   tol_reg;
  curve_vector_t vector_queue [$];

  assign pending = vector_queue.size();

  // Clamp to the signed 48-bit result range.
  function automatic longint clamp48(input longint v);
    if (v > LIM47 - 1) return LIM47 - 1;
    if (v < -LIM47) return -LIM47;
    return v;
  endfunction

  // Q16.16 product, truncated toward zero and clamped.
  function automatic longint q_product(input longint a, input longint b);
    logic          neg;
    logic [63:0]   ua;
    logic [63:0]   ub;
    logic [63:0]   hi;
    logic [63:0]   lo;
    logic [63:0]   mag;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    hi  = ub >> 16;
    lo  = ub & 64'hFFFF;
    if (hi != 0 && ua > 64'(LIM47) / hi) begin
      mag = 64'(LIM47) + 1;
    end else begin
      mag = ua * hi + ((ua * lo) >> 16);
    end
    if (neg) begin
      if (mag > 64'(LIM47)) mag = 64'(LIM47);
      return -longint'(mag);
    end
    if (mag > 64'(LIM47) - 1) mag = 64'(LIM47) - 1;
    return longint'(mag);
  endfunction

  // Work out the vectors that one evaluation word produces.
  task automatic predict_evaluation(input longint t, input int top_order);
    int            n;
    int            seg;
    longint        tol;
    longint        e;
    longint        d;
    longint        s;
    longint        s2;
    longint        s3;
    longint        s2x;
    longint        s3x2;
    longint        s6x;
    longint        r;
    longint        c [0:3];
    longint        v [0:2];
    curve_vector_t cv;
    n   = (seg_count_reg == 0) ? 1 : (seg_count_reg > MAX_SEGMENTS) ? MAX_SEGMENTS :
          int'(seg_count_reg);
    tol = longint'(tol_reg);
    if (t < bp_copy[0] - tol || t > bp_copy[n] + tol) begin
      cv = '{order: 2'd0, xv: '0, yv: '0, zv: '0, seg: '0, in_range: 1'b0, last: 1'b1};
      vector_queue.insert(vector_queue.size(), cv);
      return;
    end
    seg = n - 1;
    for (int i = 0; i < n; i++) begin
      e = bp_copy[i + 1];
      d = t - e;
      if ((d <= tol && d >= -tol) || t < e) begin
        seg = i;
        break;
      end
    end
    s    = t - bp_copy[seg];
    s2   = q_product(s, s);
    s3   = q_product(s2, s);
    s2x  = clamp48(2 * s);
    s3x2 = clamp48(3 * s2);
    s6x  = clamp48(6 * s);
    for (int k = 0; k <= top_order; k++) begin
      for (int ax = 0; ax < 3; ax++) begin
        for (int p = 0; p < 4; p++) c[p] = coef_copy[seg * 12 + ax * 4 + p];
        case (k)
          0: begin
            r = clamp48(c[0] + q_product(c[1], s));
            r = clamp48(r + q_product(c[2], s2));
            r = clamp48(r + q_product(c[3], s3));
          end
          1: begin
            r = clamp48(c[1] + q_product(c[2], s2x));
            r = clamp48(r + q_product(c[3], s3x2));
          end
          2: begin
            r = clamp48(clamp48(2 * c[2]) + q_product(c[3], s6x));
          end
          default: begin
            r = clamp48(6 * c[3]);
          end
        endcase
        v[ax] = r;
      end
      cv = '{order: k[1:0], xv: v[0][RES_W-1:0], yv: v[1][RES_W-1:0], zv: v[2][RES_W-1:0],
             seg: seg[SEG_W-1:0], in_range: 1'b1, last: (k == top_order)};
      vector_queue.insert(vector_queue.size(), cv);
    end
  endtask

  // Compare one field and count a mismatch.
  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    fail_count      = 0;
    vectors_checked = 0;
  end

  // Output words are checked before the input word of the same edge is predicted.
  always @(posedge clk) begin
    curve_vector_t w;
    if (rst) begin
      seg_count_reg <= 5'd1;
      tol_reg       <= 16'd1;
    end else begin
      if (out_valid && out_ready) begin
        vectors_checked++;
        if (vector_queue.size() == 0) begin
          $error("output word with nothing expected");
          fail_count++;
        end else begin
          w = vector_queue.pop_front();
          compare_field("order", w.order, order);
          compare_field("x_value", w.xv, x_value);
          compare_field("y_value", w.yv, y_value);
          compare_field("z_value", w.zv, z_value);
          compare_field("segment", w.seg, segment);
          compare_field("in_range", w.in_range, in_range);
          compare_field("last", w.last, last);
        end
      end
      if (in_valid && in_ready) begin
        case (op)
          OP_LOAD_BP: begin
            if (entry_index <= MAX_SEGMENTS) bp_copy[entry_index] = longint'(load_value);
          end
          OP_LOAD_COEF: begin
            if (entry_index < MAX_SEGMENTS && axis != 2'd3)
              coef_copy[entry_index * 12 + axis * 4 + power] = longint'(load_value);
          end
          OP_EVAL: predict_evaluation(longint'(param), int'(max_order));
          default: ;
        endcase
      end
      if (cfg_write_en) begin
        if (cfg_index == CFG_SEGMENT_COUNT) seg_count_reg <= cfg_data[4:0];
        else if (cfg_index == CFG_TOLERANCE) tol_reg <= cfg_data;
      end
    end
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import pce_pkg::*;

  localparam int OP_UNUSED  = 3;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_WAIT = 300;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic [1:0]                    op;
  logic [4:0]                    entry_index;
  logic [1:0]                    axis;
  logic [1:0]                    power;
  logic signed [VALUE_WIDTH-1:0] load_value;
  logic signed [VALUE_WIDTH-1:0] param;
  logic [1:0]                    max_order;
  logic                          out_valid;
  logic                          out_ready;
  logic [1:0]                    order;
  logic signed [RES_W-1:0]       x_value;
  logic signed [RES_W-1:0]       y_value;
  logic signed [RES_W-1:0]       z_value;
  logic [SEG_W-1:0]              segment;
  logic                          in_range;
  logic                          last;
  logic                          cfg_write_en;
  logic                          cfg_index;
  logic [TOL_W-1:0]              cfg_data;
  int                            fail_count;
  int                            pending;
  int                            vectors_checked;

  // Stimulus-side view of the table and registers, used to aim parameters.
  longint bp_view [0:MAX_SEGMENTS];
  int     active_n;
  longint tol_view;
  int     evals_sent;
  int     idle_cycles;
  logic   calm;
  int     stall_left;

  piecewise_cubic_evaluator u_dut (.*);

  pce_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Output side stalls at random.
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready  <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  // Watchdog on cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("piecewise_cubic_evaluator verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one input word and hold it until taken, then maybe pause.
  task automatic send_word(input int code, input int idx, input int ax, input int pw,
                           input longint lv, input longint prm, input int mo);
    int gap;
    op          <= code[1:0];
    entry_index <= idx[4:0];
    axis        <= ax[1:0];
    power       <= pw[1:0];
    load_value  <= lv[31:0];
    param       <= prm[31:0];
    max_order   <= mo[1:0];
    in_valid    <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (code == OP_EVAL) evals_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_bp(input int idx, input longint v);
    send_word(OP_LOAD_BP, idx, $urandom, $urandom, v, $urandom, $urandom);
    if (idx <= MAX_SEGMENTS) bp_view[idx] = longint'(signed'(v[31:0]));
  endtask

  task automatic load_coef(input int seg, input int ax, input int pw, input longint v);
    send_word(OP_LOAD_COEF, seg, ax, pw, v, $urandom, $urandom);
  endtask

  task automatic evaluate(input longint t, input int mo);
    send_word(OP_EVAL, $urandom, $urandom, $urandom, $urandom, t, mo);
  endtask

  // Strictly increasing breakpoints, spacing small or wide.
  task automatic load_breakpoints(input logic wide);
    longint v;
    v = -longint'($urandom_range(0, 32'h3000_0000));
    for (int i = 0; i <= MAX_SEGMENTS; i++) begin
      load_bp(i, v);
      v += wide ? longint'($urandom_range(1, 32'h0080_0000)) :
                  longint'($urandom_range(1, 32'h0004_0000));
    end
  endtask

  // A coefficient of random size, now and then at the extremes.
  function automatic longint pick_coef();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h8000_0000;
    if (r == 1) return 32'h7FFF_FFFF;
    if (r < 5) return $urandom;
    return longint'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
  endfunction

  // Parameter near a breakpoint, inside the domain, or anywhere at all.
  function automatic longint pick_param();
    int     r;
    longint lo;
    longint span;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      return bp_view[$urandom_range(0, active_n)] +
             longint'($urandom_range(0, 2 * tol_view + 6)) - tol_view - 3;
    end else if (r < 8) begin
      lo   = bp_view[0] - tol_view;
      span = bp_view[active_n] + tol_view - lo + 1;
      if (span <= 0) span = 1;
      return lo + longint'({$urandom, $urandom} % span);
    end
    return $urandom;
  endfunction

  // Registers are written only while the block is quiet.
  task automatic write_reg(input logic idx, input int value);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= value[15:0];
    @(posedge clk);
    cfg_write_en <= 1'b0;
    if (idx == CFG_SEGMENT_COUNT) begin
      active_n = (value[4:0] == 0) ? 1 : (value[4:0] > MAX_SEGMENTS) ? MAX_SEGMENTS :
                 int'(value[4:0]);
    end else begin
      tol_view = value[15:0];
    end
  endtask

  // One mixed random word.
  task automatic random_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) evaluate(pick_param(), $urandom_range(0, 3));
    else if (r < 88) load_coef($urandom_range(0, 31), $urandom_range(0, 3),
                               $urandom_range(0, 3), pick_coef());
    else if (r < 94) load_bp($urandom_range(0, 31), $urandom);
    else send_word(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  int seg_settings [6] = '{1, 16, 4, 0, 31, 9};
  int tol_settings [6] = '{1, 0, 65535, 300, 7, 1024};

  initial begin
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    op           <= '0;
    entry_index  <= '0;
    axis         <= '0;
    power        <= '0;
    load_value   <= '0;
    param        <= '0;
    max_order    <= '0;
    cfg_write_en <= 1'b0;
    cfg_index    <= 1'b0;
    cfg_data     <= '0;
    calm         = 1'b0;
    evals_sent   = 0;
    active_n     = 1;
    tol_view     = 1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Fill both tables so no evaluation reads an unwritten entry.
    calm = 1'b1;
    load_breakpoints(1'b0);
    for (int sg = 0; sg < MAX_SEGMENTS; sg++)
      for (int ax = 0; ax < 3; ax++)
        for (int pw = 0; pw < 4; pw++) load_coef(sg, ax, pw, pick_coef());
    calm = 1'b0;

    // Directed part at reset settings: ignored words, extremes, ties and the edges.
    send_word(OP_UNUSED, 31, 3, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3);
    load_bp(17, 32'h7FFF_FFFF);
    load_bp(31, 32'h8000_0000);
    load_coef(16, 0, 0, 32'h1234_5678);
    load_coef(3, 3, 2, 32'h7FFF_FFFF);
    load_coef(0, 0, 3, 32'h7FFF_FFFF);
    load_coef(0, 1, 3, 32'h8000_0000);
    load_coef(0, 2, 2, 32'h8000_0000);
    evaluate(bp_view[0], 3);
    evaluate(bp_view[0] - 1, 2);
    evaluate(bp_view[0] - 2, 0);
    evaluate(bp_view[1], 1);
    evaluate(bp_view[1] + 1, 3);
    evaluate(bp_view[1] + 2, 0);
    evaluate((bp_view[0] + bp_view[1]) / 2, 3);
    evaluate(32'h8000_0000, 3);
    evaluate(32'h7FFF_FFFF, 1);

    // Several register settings, each followed by random traffic.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_SEGMENT_COUNT, seg_settings[ph]);
      write_reg(CFG_TOLERANCE, tol_settings[ph]);
      calm = (ph == 2);
      if (ph == 3) load_breakpoints(1'b1);
      for (int j = 0; j < 13; j++) begin
        random_word();
        // Hold the sender until the output side has caught up.
        if (j == 6) begin
          in_valid <= 1'b0;
          @(posedge clk);
          wait (pending == 0);
          @(posedge clk);
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Run covered %0d evaluations and %0d output vectors over six register settings,",
             evals_sent, vectors_checked);
    $display("including ignored loads, out-of-domain points and breakpoint ties.");
    if (fail_count == 0) begin
      $display("piecewise_cubic_evaluator verification clean");
    end else begin
      $display("piecewise_cubic_evaluator verification failed");
    end
    $finish;
  end

endmodule
